// File: rtl/core/ipv_pkg.sv
package ipv_pkg;

	localparam logic [7:0] CHAR_DOT   = 8'h2E;
	localparam logic [7:0] CHAR_COLON = 8'h3A;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [7:0] CHAR_UP_A  = 8'h41;
	localparam logic [7:0] CHAR_UP_F  = 8'h46;
	localparam logic [7:0] CHAR_LO_A  = 8'h61;
	localparam logic [7:0] CHAR_LO_F  = 8'h66;

	localparam logic [9:0] V4_MAX_VALUE = 10'd255;
	localparam logic [2:0] V4_MAX_LEN   = 3'd3;
	localparam logic [2:0] V6_MAX_LEN   = 3'd4;
	localparam logic [2:0] V4_DOTS      = 3'd3;
	localparam logic [3:0] V6_COLONS    = 4'd7;
	localparam logic [2:0] DOT_SAT      = 3'd7;
	localparam logic [3:0] COLON_SAT    = 4'd15;

	typedef enum logic [1:0] {
		VERDICT_NEITHER = 2'd0,
		VERDICT_IPV4    = 2'd1,
		VERDICT_IPV6    = 2'd2
	} verdict_t;

	typedef struct packed {
		logic [7:0] char_code;
		logic       char_valid;
		logic       is_last;
	} ipv_item_t;

	function automatic logic is_dec(input logic [7:0] c);
		return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
	endfunction

	function automatic logic is_hex(input logic [7:0] c);
		return is_dec(c) || ((c >= CHAR_UP_A) && (c <= CHAR_UP_F)) ||
			((c >= CHAR_LO_A) && (c <= CHAR_LO_F));
	endfunction

endpackage

// File: rtl/core/ipv_scan.sv
module ipv_scan
	import ipv_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  ipv_item_t item,
	input  logic      step,
	output verdict_t  verdict
);

	logic       saw_dot_q, v4_failed_q, v6_failed_q, v4_first_zero_q;
	logic [2:0] dot_count_q, v4_field_len_q, v6_field_len_q;
	logic [3:0] colon_count_q;
	logic [9:0] v4_field_value_q;

	logic       saw_dot_n, v4_failed_n, v6_failed_n, v4_first_zero_n;
	logic [2:0] dot_count_n, v4_field_len_n, v6_field_len_n;
	logic [3:0] colon_count_n;
	logic [9:0] v4_field_value_n;
	logic [7:0] c;

	function automatic logic v4_field_ok(input logic [2:0] len, input logic [9:0] val,
		input logic fz);
		return (len != 3'd0) && (val <= V4_MAX_VALUE) && !(fz && (len > 3'd1));
	endfunction

	assign c = item.char_code;

	always_comb begin
		saw_dot_n        = saw_dot_q;
		v4_failed_n      = v4_failed_q;
		v6_failed_n      = v6_failed_q;
		dot_count_n      = dot_count_q;
		colon_count_n    = colon_count_q;
		v4_field_len_n   = v4_field_len_q;
		v4_field_value_n = v4_field_value_q;
		v4_first_zero_n  = v4_first_zero_q;
		v6_field_len_n   = v6_field_len_q;
		if (item.char_valid) begin
			// ipv4 side
			if (c == CHAR_DOT) begin
				saw_dot_n = 1'b1;
				if (!v4_field_ok(v4_field_len_q, v4_field_value_q, v4_first_zero_q) ||
					(dot_count_q >= V4_DOTS)) begin
					v4_failed_n = 1'b1;
				end
				if (dot_count_q != DOT_SAT) begin
					dot_count_n = dot_count_q + 3'd1;
				end
				v4_field_len_n   = 3'd0;
				v4_field_value_n = 10'd0;
				v4_first_zero_n  = 1'b0;
			end else if (is_dec(c)) begin
				if (v4_field_len_q >= V4_MAX_LEN) begin
					v4_failed_n = 1'b1;
				end else begin
					if (v4_field_len_q == 3'd0) begin
						v4_first_zero_n = (c == CHAR_ZERO);
					end
					// times ten plus the digit, value stays below 1000
					v4_field_value_n = 10'({v4_field_value_q, 3'b000} +
						{3'b000, v4_field_value_q, 1'b0} + {9'd0, c[3:0]});
					v4_field_len_n = v4_field_len_q + 3'd1;
				end
			end else begin
				v4_failed_n = 1'b1;
			end
			// ipv6 side
			if (c == CHAR_COLON) begin
				if ((v6_field_len_q == 3'd0) || (colon_count_q >= V6_COLONS)) begin
					v6_failed_n = 1'b1;
				end
				if (colon_count_q != COLON_SAT) begin
					colon_count_n = colon_count_q + 4'd1;
				end
				v6_field_len_n = 3'd0;
			end else if (is_hex(c)) begin
				if (v6_field_len_q >= V6_MAX_LEN) begin
					v6_failed_n = 1'b1;
				end else begin
					v6_field_len_n = v6_field_len_q + 3'd1;
				end
			end else begin
				v6_failed_n = 1'b1;
			end
		end
	end

	always_comb begin
		verdict = VERDICT_NEITHER;
		if (saw_dot_n) begin
			if (!v4_failed_n && (dot_count_n == V4_DOTS) &&
				v4_field_ok(v4_field_len_n, v4_field_value_n, v4_first_zero_n)) begin
				verdict = VERDICT_IPV4;
			end
		end else begin
			if (!v6_failed_n && (colon_count_n == V6_COLONS) &&
				(v6_field_len_n != 3'd0)) begin
				verdict = VERDICT_IPV6;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			saw_dot_q        <= 1'b0;
			v4_failed_q      <= 1'b0;
			v6_failed_q      <= 1'b0;
			dot_count_q      <= 3'd0;
			colon_count_q    <= 4'd0;
			v4_field_len_q   <= 3'd0;
			v4_field_value_q <= 10'd0;
			v4_first_zero_q  <= 1'b0;
			v6_field_len_q   <= 3'd0;
		end else if (step) begin
			if (item.is_last) begin
				// verdict given, start a fresh string
				saw_dot_q        <= 1'b0;
				v4_failed_q      <= 1'b0;
				v6_failed_q      <= 1'b0;
				dot_count_q      <= 3'd0;
				colon_count_q    <= 4'd0;
				v4_field_len_q   <= 3'd0;
				v4_field_value_q <= 10'd0;
				v4_first_zero_q  <= 1'b0;
				v6_field_len_q   <= 3'd0;
			end else begin
				saw_dot_q        <= saw_dot_n;
				v4_failed_q      <= v4_failed_n;
				v6_failed_q      <= v6_failed_n;
				dot_count_q      <= dot_count_n;
				colon_count_q    <= colon_count_n;
				v4_field_len_q   <= v4_field_len_n;
				v4_field_value_q <= v4_field_value_n;
				v4_first_zero_q  <= v4_first_zero_n;
				v6_field_len_q   <= v6_field_len_n;
			end
		end
	end

endmodule

// File: rtl/core/ip_address_text_validator.sv
// IP address text validator.
// The request channel (src_valid, src_stall, char_code, char_valid, is_last) carries an
// address string, one character per request. The request with is_last set closes the
// string; a request with char_valid low carries no character (used to close an empty
// string, ignored otherwise). One verdict per string leaves on the result channel
// (res_valid, res_stall, verdict): 0 neither, 1 valid IPv4, 2 valid IPv6.
// Throughput: one request per cycle, back to back across strings, while src_stall is low.
// A request is held in an input register; the per-character update of the string state
// and the verdict decode sit between that register and the result register, which
// holds the verdict shown with res_valid.
// When the receiver stalls, the verdict holds in the result register; the block keeps
// taking characters, and src_stall rises only when a second verdict is ready while the
// first still waits.
// Reset (arst_n low, asynchronous) clears the valid flags of both registers and the
// string state, so the first request after reset starts a new string.
module ip_address_text_validator
	import ipv_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       src_valid,
	output logic       src_stall,
	input  logic [7:0] char_code,
	input  logic       char_valid,
	input  logic       is_last,
	output logic       res_valid,
	input  logic       res_stall,
	output logic [1:0] verdict
);

	logic      valid_s1;
	ipv_item_t item_s1;
	logic      res_full_q;
	verdict_t  verdict_q;
	verdict_t  verdict_c;
	logic      step;
	logic      load_s1;
	logic      load_res;

	// a character without a verdict never waits on the result side
	assign step     = valid_s1 && (!item_s1.is_last || !res_full_q || !res_stall);
	assign src_stall = valid_s1 && !step;
	assign load_s1  = src_valid && !src_stall;
	assign load_res = step && item_s1.is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1 || step) begin
			valid_s1 <= load_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			item_s1 <= '{char_code: char_code, char_valid: char_valid, is_last: is_last};
		end
	end

	ipv_scan u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_s1),
		.step    (step),
		.verdict (verdict_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_full_q <= 1'b0;
		end else if (load_res) begin
			res_full_q <= 1'b1;
		end else if (!res_stall) begin
			res_full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_res) begin
			verdict_q <= verdict_c;
		end
	end

	assign res_valid = res_full_q;
	assign verdict   = verdict_q;

endmodule

// File: rtl/core/ipv_check.sv
module ipv_check
	import ipv_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       src_valid,
	input logic       src_stall,
	input logic       is_last,
	input logic       res_valid,
	input logic       res_stall,
	input logic [1:0] verdict
);

	logic last_taken;

	assign last_taken = src_valid && !src_stall && is_last;

	// a held result keeps its valid
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid)
		else $error("result dropped while stalled");

	// a held result keeps its verdict
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> $stable(verdict))
		else $error("verdict changed while stalled");

	// requests back up only behind a stalled result
	assert property (@(posedge clk) disable iff (!arst_n)
		src_stall |-> (res_valid && res_stall))
		else $error("request stalled with result side free");

	// no verdict appears without a closing request just before
	assert property (@(posedge clk) disable iff (!arst_n)
		$past(!last_taken) && !last_taken && !res_valid |=> !res_valid)
		else $error("verdict without a closing request");

	// a verdict never carries an unused code
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (verdict == VERDICT_NEITHER || verdict == VERDICT_IPV4 ||
			verdict == VERDICT_IPV6))
		else $error("verdict code out of range");

endmodule

bind ip_address_text_validator ipv_check u_ipv_check (.*);
